@@ hw/rtl/mcpq_pkg.sv @@
package mcpq_pkg;

    // Field widths fixed by the interface.
    localparam int MASK_W    = 4;
    localparam int TS_W      = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [MASK_W-1:0]    mask_t;
    typedef logic [TS_W-1:0]      stamp_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Signed time difference of two unsigned stamps, one bit wider so it never wraps.
    typedef logic signed [TS_W:0] gap_t;

    // Register indexes on the configuration port.
    localparam cfg_idx_t CFG_MERGE_GAP = 2'd0;
    localparam cfg_idx_t CFG_CONFIRM   = 2'd1;
    localparam cfg_idx_t CFG_HOLD      = 2'd2;

    // Register reset values in milliseconds.
    localparam cfg_val_t MERGE_GAP_RST = 16'd500;
    localparam cfg_val_t CONFIRM_RST   = 16'd2000;
    localparam cfg_val_t HOLD_RST      = 16'd3000;

    // Exact difference now - then, where both are unsigned stamps.
    function automatic gap_t stamp_diff(input stamp_t now, input stamp_t then);
        stamp_diff = $signed({1'b0, now}) - $signed({1'b0, then});
    endfunction

    // A register value widened to the signed difference type.
    function automatic gap_t cfg_as_gap(input cfg_val_t v);
        cfg_as_gap = $signed({{(TS_W + 1 - CFG_W){1'b0}}, v});
    endfunction

endpackage

@@ hw/rtl/multi_channel_presence_qualifier.sv @@
// Multi-channel presence qualifier.
//
// Input channel (s_*): one transaction carries a detection mask, one bit per
// detector channel, and the current time in milliseconds. A zero mask is a
// pure query. Result channel (m_*): every input transaction yields exactly one
// result transaction with the mask of channels whose confirmed presence ended
// less than hold_time_ms ago. Configuration channel (cfg_*): writes the merge
// gap, confirm time and hold time registers; it is always ready, and writes
// are meant to happen only while no transaction is in flight.
//
// A transaction taken into the input register moves on into the result
// register and then shows on m_*. Throughput is one transaction per cycle
// while the receiver takes results: an input register feeds one pass of
// per-channel 33-bit subtract-and-compare logic into the result register.
// When the receiver stalls, the result register holds its value and the input
// register keeps one more transaction before s_ready drops.
// Reset (synchronous, active low) empties both stages, restores the register
// defaults and puts every channel's run start in the far past with run end
// and confirmed end at time zero.
module multi_channel_presence_qualifier #(
    parameter int CHANNELS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  mcpq_pkg::mask_t     s_detect_mask,
    input  mcpq_pkg::stamp_t    s_timestamp_ms,

    output logic                m_valid,
    input  logic                m_ready,
    output mcpq_pkg::mask_t     m_present_mask,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mcpq_pkg::cfg_idx_t  cfg_index,
    input  mcpq_pkg::cfg_val_t  cfg_wdata
);
    import mcpq_pkg::*;

    // Only channels that own a mask bit can ever change or be reported, so
    // only those get storage.
    localparam int LANES = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

    // Configuration registers.
    cfg_val_t merge_gap_reg;
    cfg_val_t confirm_reg;
    cfg_val_t hold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_gap_reg <= MERGE_GAP_RST;
            confirm_reg   <= CONFIRM_RST;
            hold_reg      <= HOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MERGE_GAP: merge_gap_reg <= cfg_wdata;
                CFG_CONFIRM:   confirm_reg   <= cfg_wdata;
                CFG_HOLD:      hold_reg      <= cfg_wdata;
                default: begin
                    // Unknown index: the write is dropped.
                end
            endcase
        end
    end

    // Pipeline control. The result stage frees up when it is empty or its
    // transaction is being taken; the input stage then moves into it.
    logic   in_vld_reg;
    mask_t  in_mask_reg;
    stamp_t in_ts_reg;
    logic   out_vld_reg;
    mask_t  present_reg;
    mask_t  present_next;
    logic   advance;
    logic   process;

    assign advance = !out_vld_reg || m_ready;
    assign process = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mask_reg <= s_detect_mask;
            in_ts_reg   <= s_timestamp_ms;
        end
        if (process) begin
            present_reg <= present_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_present_mask = present_reg;

    // Per-channel run state. A run start that was never set by a detection is
    // the far-past reset value, held as a flag: from there any run is longer
    // than the largest confirm time.
    logic   start_far_reg  [LANES];
    stamp_t run_start_reg  [LANES];
    stamp_t run_end_reg    [LANES];
    stamp_t conf_end_reg   [LANES];
    logic   start_far_next [LANES];
    stamp_t run_start_next [LANES];
    stamp_t run_end_next   [LANES];
    stamp_t conf_end_next  [LANES];
    logic   confirm_hit    [LANES];

    always_comb begin
        present_next = '0;
        for (int k = 0; k < LANES; k++) begin
            logic hit;
            logic merge;
            logic long_run;
            logic in_hold;
            hit      = in_mask_reg[k];
            merge    = stamp_diff(in_ts_reg, run_end_reg[k]) < cfg_as_gap(merge_gap_reg);
            long_run = start_far_reg[k] ||
                       (stamp_diff(in_ts_reg, run_start_reg[k]) > cfg_as_gap(confirm_reg));
            in_hold  = stamp_diff(in_ts_reg, conf_end_reg[k]) < cfg_as_gap(hold_reg);

            start_far_next[k] = start_far_reg[k];
            run_start_next[k] = run_start_reg[k];
            run_end_next[k]   = run_end_reg[k];
            conf_end_next[k]  = conf_end_reg[k];
            confirm_hit[k]    = hit && merge && long_run;

            if (hit) begin
                run_end_next[k] = in_ts_reg;
                if (!merge) begin
                    start_far_next[k] = 1'b0;
                    run_start_next[k] = in_ts_reg;
                end
            end
            if (confirm_hit[k]) begin
                conf_end_next[k] = in_ts_reg;
            end

            // A channel confirmed by this very transaction ended now, so it
            // reports present for any nonzero hold time.
            present_next[k] = confirm_hit[k] ? (hold_reg != '0) : in_hold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANES; k++) begin
                start_far_reg[k] <= 1'b1;
                run_start_reg[k] <= '0;
                run_end_reg[k]   <= '0;
                conf_end_reg[k]  <= '0;
            end
        end else if (process) begin
            for (int k = 0; k < LANES; k++) begin
                start_far_reg[k] <= start_far_next[k];
                run_start_reg[k] <= run_start_next[k];
                run_end_reg[k]   <= run_end_next[k];
                conf_end_reg[k]  <= conf_end_next[k];
            end
        end
    end

`ifndef SYNTHESIS
    // A transaction waiting in the input stage is never overwritten.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_ts_reg) && $stable(in_mask_reg))
        else $error("input stage lost a waiting transaction");

    // Every processed transaction lands in the result stage.
    a_proc_out: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> out_vld_reg)
        else $error("processed transaction produced no result");

    // Channel state changes only when a transaction is processed.
    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !process |=> $stable(run_end_reg[0]) && $stable(conf_end_reg[0])
                     && $stable(start_far_reg[0]))
        else $error("channel state changed without a transaction");

    // A confirmation sets the confirmed end to the new run end.
    a_confirm: assert property (@(posedge aclk) disable iff (!aresetn)
        process && confirm_hit[0] |=> conf_end_reg[0] == run_end_reg[0])
        else $error("confirmed end differs from run end after confirmation");

    // A run start in the far past is only left by a new run.
    a_far_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(start_far_reg[0]) |-> run_start_reg[0] == run_end_reg[0])
        else $error("run start left the far past without a new run");
`endif

endmodule

@@ test/multi_channel_presence_qualifier_tb.sv @@
`timescale 1ns / 100ps

module multi_channel_presence_qualifier_tb;

    import mcpq_pkg::*;

    // Number of detector channels. It matches the default of the block.
    localparam int CH = 4;

    // A watchdog ends the run when this many cycles in a row pass without
    // any transaction on any channel.
    localparam int STALL_LIMIT = 2000;

    // Index 3 is not a register. A write to it must leave every register as it was.
    localparam cfg_idx_t CFG_SPARE_IDX = 2'd3;

    // Run times are kept as 40-bit signed milliseconds; the block keeps 32-bit stamps.
    // Differences are formed one bit wider so that they can never wrap.
    typedef logic signed [39:0] ms40_t;
    typedef logic signed [40:0] span_t;

    localparam ms40_t FAR_PAST_MS = -40'sd99999999000;

    logic     aclk           = 1'b0;
    logic     aresetn        = 1'b0;

    logic     s_valid        = 1'b0;
    logic     s_ready;
    mask_t    s_detect_mask  = '0;
    stamp_t   s_timestamp_ms = '0;

    logic     m_valid;
    logic     m_ready        = 1'b0;
    mask_t    m_present_mask;

    logic     cfg_valid      = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index      = '0;
    cfg_val_t cfg_wdata      = '0;

    // Our own copy of the registers and of the per-channel run state.
    cfg_val_t merge_gap_cfg;
    cfg_val_t confirm_cfg;
    cfg_val_t hold_cfg;
    ms40_t    run_begin      [CH];
    ms40_t    run_last       [CH];
    ms40_t    confirmed_last [CH];

    // Presence masks still owed by the block, oldest first.
    mask_t    presence_expected [$];

    int       error_count    = 0;
    int       stall_cycles   = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    int       ready_hold_left = 0;
    bit       offering       = 1'b0;
    stamp_t   clock_ms;

    multi_channel_presence_qualifier u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_detect_mask  (s_detect_mask),
        .s_timestamp_ms (s_timestamp_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_present_mask (m_present_mask),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // 2 ns clock period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Sign-extends a stored 40-bit time to the width used for differences.
    function automatic span_t widen(input ms40_t v);
        return $signed({v[39], v});
    endfunction

    // Puts the predictor into the state that reset gives the block.
    function automatic void reset_presence_state();
        merge_gap_cfg = MERGE_GAP_RST;
        confirm_cfg   = CONFIRM_RST;
        hold_cfg      = HOLD_RST;
        for (int k = 0; k < CH; k++) begin
            run_begin[k]      = FAR_PAST_MS;
            run_last[k]       = '0;
            confirmed_last[k] = '0;
        end
    endfunction

    // Applies one detection transaction to the channel state and returns the
    // presence mask that the block must report for it. Every difference is
    // exact and signed, so a timestamp older than a stored time always falls
    // below the merge gap and the hold time.
    function automatic mask_t predict_presence(input mask_t detect, input stamp_t ts);
        span_t now_ms;
        span_t merge_lim;
        span_t confirm_lim;
        span_t hold_lim;
        mask_t present;
        now_ms      = $signed({9'b0, ts});
        merge_lim   = $signed({25'b0, merge_gap_cfg});
        confirm_lim = $signed({25'b0, confirm_cfg});
        hold_lim    = $signed({25'b0, hold_cfg});
        present     = '0;
        for (int k = 0; k < CH; k++) begin
            if (detect[k]) begin
                if (now_ms - widen(run_last[k]) < merge_lim) begin
                    // Close enough to the current run: extend it, and confirm
                    // once the run has lasted longer than the confirm time.
                    run_last[k] = now_ms[39:0];
                    if (now_ms - widen(run_begin[k]) > confirm_lim) begin
                        confirmed_last[k] = run_last[k];
                    end
                end else begin
                    run_begin[k] = now_ms[39:0];
                    run_last[k]  = now_ms[39:0];
                end
            end
        end
        for (int k = 0; k < CH; k++) begin
            if (now_ms - widen(confirmed_last[k]) < hold_lim) begin
                present[k] = 1'b1;
            end
        end
        return present;
    endfunction

    // Offers one detection transaction and waits until the block takes it.
    // The sender may first idle for a random number of cycles.
    task automatic send_reading(input mask_t detect, input stamp_t ts);
        while ($urandom_range(99) < send_idle_pct) begin
            if (offering) begin
                s_valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_detect_mask  <= detect;
        s_timestamp_ms <= ts;
        offering = 1'b1;
        // s_ready is sampled at the edge, before the block updates it, so a
        // high value here means the transaction was taken at this edge.
        do @(posedge aclk); while (!s_ready);
        presence_expected.push_back(predict_presence(detect, ts));
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic drain_results();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (presence_expected.size() != 0) @(posedge aclk);
    endtask

    // Writes all three registers, plus a junk write to the unused index,
    // while the block is idle. The valid stays high across the four writes.
    task automatic apply_settings(input cfg_val_t merge, input cfg_val_t confirm,
                                  input cfg_val_t hold);
        cfg_idx_t idx_list [4];
        cfg_val_t val_list [4];
        idx_list = '{CFG_MERGE_GAP, CFG_CONFIRM, CFG_HOLD, CFG_SPARE_IDX};
        val_list = '{merge, confirm, hold, cfg_val_t'($urandom)};
        drain_results();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_wdata <= val_list[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx_list[i])
                CFG_MERGE_GAP: merge_gap_cfg = val_list[i];
                CFG_CONFIRM:   confirm_cfg   = val_list[i];
                CFG_HOLD:      hold_cfg      = val_list[i];
                default: begin
                    // Out-of-range index: the write has no effect.
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // A register value for a random phase. Zero and all ones come up often.
    function automatic cfg_val_t pick_setting();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return cfg_val_t'($urandom_range(1, 100));
            3:       return cfg_val_t'($urandom_range(100, 5000));
            default: return cfg_val_t'($urandom);
        endcase
    endfunction

    // Right after reset: every channel reports present until the hold time
    // has passed since time zero, and a detection just after time zero joins
    // the far-past run and confirms at once.
    task automatic test_power_up();
        send_reading(4'b0000, 32'd0);
        send_reading(4'b0001, 32'd499);
        send_reading(4'b0000, 32'd3000);
        send_reading(4'b0010, 32'd3000);
    endtask

    // Exact edges of the default registers. Channel 1 builds a run in steps
    // just under the merge gap, reaches exactly the confirm time without
    // confirming, confirms one millisecond later, and then drops out exactly
    // at the end of the hold time. Channel 2 sees a gap of exactly the merge
    // gap, which must start a new run, and then a timestamp going backwards.
    task automatic test_default_boundaries();
        send_reading(4'b0010, 32'd3499);
        send_reading(4'b0010, 32'd3998);
        send_reading(4'b0010, 32'd4497);
        send_reading(4'b0010, 32'd4996);
        send_reading(4'b0010, 32'd5000);
        send_reading(4'b0010, 32'd5001);
        send_reading(4'b0000, 32'd8000);
        send_reading(4'b0000, 32'd8001);
        send_reading(4'b0100, 32'd8001);
        send_reading(4'b0100, 32'd8501);
        send_reading(4'b0100, 32'd100);
    endtask

    // Register extremes: all ones, all zeros, and a mix at the top of the
    // timestamp range, where a wrap back to zero reads as time going backwards.
    task automatic test_register_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(4'b0100, 32'd100000);
        send_reading(4'b0100, 32'd165535);
        send_reading(4'b0100, 32'd165536);
        send_reading(4'b0000, 32'd231070);
        send_reading(4'b0000, 32'd231071);

        // With both limits at zero only a backward timestamp merges or reports.
        apply_settings(16'h0000, 16'h0000, 16'h0000);
        send_reading(4'b1111, 32'd231071);
        send_reading(4'b1111, 32'd231071);
        send_reading(4'b0011, 32'd231070);

        apply_settings(16'hFFFF, 16'h0000, 16'hFFFF);
        send_reading(4'b1111, 32'hFFFF_0000);
        send_reading(4'b1010, 32'hFFFF_FFFE);
        send_reading(4'b0000, 32'hFFFF_FFFF);
        send_reading(4'b0000, 32'h0000_0000);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block fills up and drops s_ready. Afterwards the
    // sender pauses until every result is back.
    task automatic test_backpressure_fill();
        stamp_t ts;
        apply_settings(MERGE_GAP_RST, CONFIRM_RST, HOLD_RST);
        send_idle_pct   = 0;
        ts              = 32'd400000;
        ready_hold_left = 60;
        for (int i = 0; i < 16; i++) begin
            ts = ts + 32'd300;
            send_reading(mask_t'($urandom_range(1, 15)), ts);
        end
        drain_results();
    endtask

    // Random traffic: bursts of detections on a few channels, mostly spaced
    // within the merge gap so that runs grow and confirm, mixed with long
    // gaps, backward steps, full-range noise and trailing queries that probe
    // how the hold time runs out.
    task automatic run_random_traffic(input int count);
        int    left;
        int    burst_len;
        int    kind;
        mask_t burst_mask;
        mask_t detect;
        left = count;
        while (left > 0) begin
            burst_len  = $urandom_range(3, 20);
            burst_mask = mask_t'($urandom_range(1, 15));
            for (int i = 0; i < burst_len && left > 0; i++) begin
                kind   = $urandom_range(99);
                detect = ($urandom_range(9) < 8) ? burst_mask : mask_t'($urandom_range(0, 15));
                if (kind < 80) begin
                    clock_ms = clock_ms + stamp_t'($urandom_range(0, merge_gap_cfg));
                end else if (kind < 88) begin
                    clock_ms = clock_ms + stamp_t'($urandom_range(0,
                               2 * int'(hold_cfg) + int'(merge_gap_cfg) + 10));
                end else if (kind < 94) begin
                    clock_ms = clock_ms - stamp_t'($urandom_range(0, 3000));
                end else begin
                    clock_ms = $urandom;
                end
                send_reading(detect, clock_ms);
                left--;
            end
            repeat ($urandom_range(0, 3)) begin
                if (left > 0) begin
                    clock_ms = clock_ms + stamp_t'($urandom_range(0,
                               int'(hold_cfg) + int'(hold_cfg) / 4 + 2));
                    send_reading(4'b0000, clock_ms);
                    left--;
                end
            end
        end
    endtask

    // One random phase at the given idle rates, split into chunks that each
    // run under fresh register settings.
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            if (chunk == 0) begin
                apply_settings(MERGE_GAP_RST, CONFIRM_RST, HOLD_RST);
            end else begin
                apply_settings(pick_setting(), pick_setting(), pick_setting());
            end
            run_random_traffic(count / 4);
        end
        drain_results();
    endtask

    // Result side: random stalls, or a counted hold-off when one is asked for.
    always @(posedge aclk) begin
        if (ready_hold_left > 0) begin
            m_ready <= 1'b0;
            ready_hold_left = ready_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transaction is matched against the oldest owed mask.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (presence_expected.size() == 0) begin
                $error("present_mask: result with nothing expected, actual %h",
                       m_present_mask);
                error_count++;
            end else begin
                mask_t want;
                want = presence_expected.pop_front();
                if (m_present_mask !== want) begin
                    $error("present_mask mismatch: expected %h, actual %h",
                           want, m_present_mask);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("multi_channel_presence_qualifier_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        reset_presence_state();
        send_idle_pct = 8;
        recv_idle_pct = 54;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_up();
        test_default_boundaries();
        test_register_extremes();
        test_backpressure_fill();

        clock_ms = 32'd1000000;
        test_random_phase(8, 54, 400);
        test_random_phase(54, 8, 400);
        test_random_phase(0, 0, 400);

        drain_results();
        // The block has two stages, so any stray result shows up before the
        // final check below.
        repeat (8) @(posedge aclk);
        if (presence_expected.size() != 0) begin
            $error("present_mask: %0d results never arrived", presence_expected.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("multi_channel_presence_qualifier_tb: done, clean");
        end else begin
            $display("multi_channel_presence_qualifier_tb: done, errors");
        end
        $finish;
    end

endmodule
